// File: hw/rtl/rau_pkg.sv
`default_nettype none

package rau_pkg;

  // fixed widths of the stream fields
  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned DEN_OUT_W   = 31;
  localparam int unsigned S_TDATA_W   = 4 * FIELD_W;
  localparam int unsigned M_TDATA_W   = ((FIELD_W + DEN_OUT_W + 7) / 8) * 8;
  localparam int unsigned TUSER_W     = 2;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

endpackage

`default_nettype wire

// File: hw/rtl/rau_mul.sv
`default_nettype none

// Shift-add multiplier, one multiplier bit per cycle.
module rau_mul #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [WIDTH-1:0]     a_i,
  input  wire logic [WIDTH-1:0]     b_i,
  output logic                      done_o,
  output logic [2*WIDTH-1:0]        prod_o
);

  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] mc_q;
  logic [WIDTH-1:0] hi_q;
  logic [WIDTH-1:0] lo_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [WIDTH:0]   sum;

  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mc_q} : {(WIDTH + 1){1'b0}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mc_q   <= '0;
      hi_q   <= '0;
      lo_q   <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        mc_q   <= a_i;
        hi_q   <= '0;
        lo_q   <= b_i;
        cnt_q  <= CW'(WIDTH);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        hi_q  <= sum[WIDTH:1];
        lo_q  <= {sum[0], lo_q[WIDTH-1:1]};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

`default_nettype wire

// File: hw/rtl/rau_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle over a W-bit word.
// Divisor must be nonzero.
module rau_div #(
  parameter int unsigned W = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              done_o,
  output logic [W-1:0]      quotient_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem_q;
  logic [W-1:0]  quo_q;
  logic [W-1:0]  dvs_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [W:0]    shifted;
  logic [W+1:0]  trial;

  assign shifted = {rem_q, quo_q[W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= '0;
        quo_q  <= dividend_i;
        dvs_q  <= divisor_i;
        cnt_q  <= CW'(W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        // borrow set: keep the shifted remainder, quotient bit zero
        if (trial[W+1]) begin
          rem_q <= shifted[W-1:0];
          quo_q <= {quo_q[W-2:0], 1'b0};
        end else begin
          rem_q <= trial[W-1:0];
          quo_q <= {quo_q[W-2:0], 1'b1};
        end
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// File: hw/rtl/rational_arithmetic_unit.sv
`default_nettype none

// Rational arithmetic unit: adds, subtracts, multiplies or divides two signed
// fractions and returns the result reduced to lowest terms with a positive
// denominator (zero as 0/1), or a zero-denominator or overflow status with
// 0/0. One item is worked at a time and s_axis_tready is high only while the
// unit is idle; a finished result waits in the output register without
// blocking the next transfer in. The time an item takes is set by the
// shift-add multiplier (two products, three for add and subtract), the binary
// GCD sequencer (one shift or subtract per cycle) and the restoring divider
// (two quotients). An item with a zero denominator, or a divide by a zero
// fraction, skips the arithmetic and goes from S_IDLE straight to S_OUT.
// Every item takes longer while an earlier result still waits at the output.
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // a_num [31:0], a_den [63:32], b_num [95:64], b_den [127:96]
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  // action [1:0]
  input  wire logic [TUSER_W-1:0]   s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // result_num [31:0], result_den [62:32], zero pad [63]
  output logic [M_TDATA_W-1:0]      m_axis_tdata,
  // status [1:0]
  output logic [TUSER_W-1:0]        m_axis_tuser
);

  localparam int unsigned PW = 2 * WIDTH;
  localparam logic [PW-1:0] LIM = PW'(1) << (WIDTH - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_COMB,
    S_COMMON,
    S_REDUCE,
    S_DIV0,
    S_DIV1,
    S_CHECK,
    S_OUT
  } state_e;

  state_e state_q;

  // operand magnitudes and signs
  logic [WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
  logic             sa_q, sb_q;
  action_e          act_q;

  logic [PW-1:0] x0_q, x1_q, x2_q;
  logic [PW-1:0] u_q, v_q;
  logic          neg_q;

  logic [FIELD_W-1:0]   rnum_q, res_num_q;
  logic [DEN_OUT_W-1:0] rden_q, res_den_q;
  status_e              rstat_q, res_stat_q;
  logic                 m_valid_q;

  logic mul_start_q, div_start_q;

  // input unpacking
  logic [WIDTH-1:0] raw_an, raw_ad, raw_bn, raw_bd;
  logic [WIDTH-1:0] in_an, in_ad, in_bn, in_bd;
  action_e          in_act;
  logic             in_zero;

  assign raw_an = s_axis_tdata[WIDTH-1:0];
  assign raw_ad = s_axis_tdata[FIELD_W+WIDTH-1:FIELD_W];
  assign raw_bn = s_axis_tdata[2*FIELD_W+WIDTH-1:2*FIELD_W];
  assign raw_bd = s_axis_tdata[3*FIELD_W+WIDTH-1:3*FIELD_W];
  assign in_act = action_e'(s_axis_tuser);

  always_comb begin
    in_an = raw_an[WIDTH-1] ? (~raw_an + 1'b1) : raw_an;
    in_ad = raw_ad[WIDTH-1] ? (~raw_ad + 1'b1) : raw_ad;
    in_bn = raw_bn[WIDTH-1] ? (~raw_bn + 1'b1) : raw_bn;
    in_bd = raw_bd[WIDTH-1] ? (~raw_bd + 1'b1) : raw_bd;
    in_zero = (raw_ad == '0) || (raw_bd == '0) || ((in_act == ACT_DIV) && (raw_bn == '0));
  end

  // shared multiplier
  logic [WIDTH-1:0] mul_a, mul_b;
  logic             mul_done;
  logic [PW-1:0]    mul_prod;

  always_comb begin
    mul_a = an_q;
    mul_b = bd_q;
    unique case (state_q)
      S_MUL0: begin
        mul_a = an_q;
        mul_b = (act_q == ACT_MUL) ? bn_q : bd_q;
      end
      S_MUL1: begin
        mul_a = ad_q;
        mul_b = (act_q == ACT_DIV) ? bn_q : bd_q;
      end
      S_MUL2: begin
        mul_a = bn_q;
        mul_b = ad_q;
      end
      default: ;
    endcase
  end

  rau_mul #(
    .WIDTH (WIDTH)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // shared divider, always by the odd part of the gcd
  logic [PW-1:0] div_n;
  logic          div_done;
  logic [PW-1:0] div_quo;

  assign div_n = (state_q == S_DIV0) ? x0_q : x1_q;

  rau_div #(
    .W (PW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_n),
    .divisor_i  (u_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // signed combination of the cross products
  logic          sq, addsub;
  logic [PW-1:0] mag_c;
  logic          neg_c;

  always_comb begin
    addsub = (act_q == ACT_ADD) || (act_q == ACT_SUB);
    sq     = (act_q == ACT_SUB) ? !sb_q : sb_q;
    mag_c  = x0_q;
    neg_c  = sa_q ^ sb_q;
    if (addsub) begin
      if (sa_q == sq) begin
        mag_c = x0_q + x2_q;
        neg_c = sa_q;
      end else if (x0_q >= x2_q) begin
        mag_c = x0_q - x2_q;
        neg_c = sa_q;
      end else begin
        mag_c = x2_q - x0_q;
        neg_c = sq;
      end
    end
  end

  // binary gcd step on odd-reduced pair
  logic          u_lt_v;
  logic [PW-1:0] gcd_min, gcd_diff;

  always_comb begin
    u_lt_v   = u_q < v_q;
    gcd_min  = u_lt_v ? u_q : v_q;
    gcd_diff = u_lt_v ? (v_q - u_q) : (u_q - v_q);
  end

  // range check and final signed numerator
  logic                    fit;
  logic signed [WIDTH-1:0] num_w;

  always_comb begin
    fit   = (x1_q[PW-1:WIDTH-1] == '0) &&
            ((x0_q[PW-1:WIDTH-1] == '0) || (neg_q && (x0_q == LIM)));
    num_w = neg_q ? (~x0_q[WIDTH-1:0] + 1'b1) : x0_q[WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      m_valid_q   <= 1'b0;
      an_q        <= '0;
      ad_q        <= '0;
      bn_q        <= '0;
      bd_q        <= '0;
      sa_q        <= 1'b0;
      sb_q        <= 1'b0;
      act_q       <= ACT_ADD;
      x0_q        <= '0;
      x1_q        <= '0;
      x2_q        <= '0;
      u_q         <= '0;
      v_q         <= '0;
      neg_q       <= 1'b0;
      rnum_q      <= '0;
      rden_q      <= '0;
      rstat_q     <= ST_OK;
      res_num_q   <= '0;
      res_den_q   <= '0;
      res_stat_q  <= ST_OK;
    end else begin
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      // S_OUT reloads the output register itself
      if (m_valid_q && m_axis_tready && (state_q != S_OUT)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            an_q  <= in_an;
            ad_q  <= in_ad;
            bn_q  <= in_bn;
            bd_q  <= in_bd;
            sa_q  <= raw_an[WIDTH-1] ^ raw_ad[WIDTH-1];
            sb_q  <= raw_bn[WIDTH-1] ^ raw_bd[WIDTH-1];
            act_q <= in_act;
            if (in_zero) begin
              rnum_q  <= '0;
              rden_q  <= '0;
              rstat_q <= ST_ZERO_DEN;
              state_q <= S_OUT;
            end else begin
              mul_start_q <= 1'b1;
              state_q     <= S_MUL0;
            end
          end
        end
        S_MUL0: begin
          if (mul_done) begin
            x0_q        <= mul_prod;
            mul_start_q <= 1'b1;
            state_q     <= S_MUL1;
          end
        end
        S_MUL1: begin
          if (mul_done) begin
            x1_q <= mul_prod;
            if (addsub) begin
              mul_start_q <= 1'b1;
              state_q     <= S_MUL2;
            end else begin
              state_q <= S_COMB;
            end
          end
        end
        S_MUL2: begin
          if (mul_done) begin
            x2_q    <= mul_prod;
            state_q <= S_COMB;
          end
        end
        S_COMB: begin
          u_q     <= mag_c;
          v_q     <= x1_q;
          neg_q   <= neg_c;
          state_q <= S_COMMON;
        end
        S_COMMON: begin
          if (u_q == '0) begin
            rnum_q  <= '0;
            rden_q  <= DEN_OUT_W'(1);
            rstat_q <= ST_OK;
            state_q <= S_OUT;
          end else if (!u_q[0] && !v_q[0]) begin
            // strip common powers of two from both terms
            u_q <= u_q >> 1;
            v_q <= v_q >> 1;
          end else begin
            x0_q    <= u_q;
            x1_q    <= v_q;
            state_q <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          if (v_q == '0) begin
            div_start_q <= 1'b1;
            state_q     <= S_DIV0;
          end else if (!u_q[0]) begin
            u_q <= u_q >> 1;
          end else if (!v_q[0]) begin
            v_q <= v_q >> 1;
          end else begin
            u_q <= gcd_min;
            v_q <= gcd_diff;
          end
        end
        S_DIV0: begin
          if (div_done) begin
            x0_q        <= div_quo;
            div_start_q <= 1'b1;
            state_q     <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            x1_q    <= div_quo;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (fit) begin
            rnum_q  <= FIELD_W'(num_w);
            rden_q  <= DEN_OUT_W'(x1_q[WIDTH-2:0]);
            rstat_q <= ST_OK;
          end else begin
            rnum_q  <= '0;
            rden_q  <= '0;
            rstat_q <= ST_OVERFLOW;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            res_num_q  <= rnum_q;
            res_den_q  <= rden_q;
            res_stat_q <= rstat_q;
            m_valid_q  <= 1'b1;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = M_TDATA_W'({res_den_q, res_num_q});
  assign m_axis_tuser  = res_stat_q;

  // gcd pair never loses its odd member, so the divisor cannot be zero
  a_gcd_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REDUCE) |-> (u_q[0] || v_q[0]))
    else $error("gcd pair has no odd term");

  a_zero_den_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && in_zero) |=>
      (state_q == S_OUT && rstat_q == ST_ZERO_DEN))
    else $error("zero denominator not flagged");

  a_ok_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && res_stat_q == ST_OK) |-> (res_den_q != '0))
    else $error("ok result with zero denominator");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && res_stat_q != ST_OK) |-> (res_num_q == '0 && res_den_q == '0))
    else $error("error result not cleared");

endmodule

`default_nettype wire

// File: verif/tb_rational_arithmetic_unit.sv
`timescale 1ns / 1ps

module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  localparam int unsigned WIDTH = 32;
  // the limit covers the worst case per item with stalls over about 650 items, taken
  // several times
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned TAIL_CYCLES = 500;

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    status_e     status;
  } ratio_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [TUSER_W-1:0]   s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [TUSER_W-1:0]   m_axis_tuser;

  ratio_t      expected_ratios[$];
  int unsigned mismatches;
  int unsigned cycle_count = 0;
  bit          tx_idle_en;
  bit          rx_idle_en;
  int unsigned rx_hold_cycles;

  rational_arithmetic_unit #(
    .WIDTH(WIDTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // low WIDTH bits of an operand as sign and magnitude
  function automatic void split_signed(input logic [31:0] raw, output logic [63:0] mag,
                                       output bit neg);
    logic [63:0] v;
    v   = 64'(raw) & ((64'd1 << WIDTH) - 64'd1);
    neg = v[WIDTH-1];
    mag = neg ? (64'd1 << WIDTH) - v : v;
  endfunction

  function automatic ratio_t reduce_fraction_op(input action_e op,
                                                input logic [31:0] an_raw, ad_raw,
                                                input logic [31:0] bn_raw, bd_raw);
    logic [63:0] an, ad, bn, bd, p, q, mag, den, g_a, g_b, rem, lim;
    bit          san, sad, sbn, sbd, sa, sb, sq, neg;
    ratio_t      r;
    split_signed(an_raw, an, san);
    split_signed(ad_raw, ad, sad);
    split_signed(bn_raw, bn, sbn);
    split_signed(bd_raw, bd, sbd);
    sa       = san ^ sad;
    sb       = sbn ^ sbd;
    r.num    = '0;
    r.den    = '0;
    r.status = ST_ZERO_DEN;
    if (ad == 0 || bd == 0 || (op == ACT_DIV && bn == 0)) return r;
    case (op)
      ACT_MUL: begin
        mag = an * bn;
        den = ad * bd;
        neg = sa ^ sb;
      end
      ACT_DIV: begin
        mag = an * bd;
        den = ad * bn;
        neg = sa ^ sb;
      end
      default: begin
        p   = an * bd;
        q   = bn * ad;
        sq  = (op == ACT_SUB) ? !sb : sb;
        den = ad * bd;
        if (sa == sq) begin
          mag = p + q;
          neg = sa;
        end else if (p >= q) begin
          mag = p - q;
          neg = sa;
        end else begin
          mag = q - p;
          neg = sq;
        end
      end
    endcase
    r.status = ST_OK;
    if (mag == 0) begin
      r.den = 31'd1;
      return r;
    end
    g_a = mag;
    g_b = den;
    while (g_b != 0) begin
      rem = g_a % g_b;
      g_a = g_b;
      g_b = rem;
    end
    mag = mag / g_a;
    den = den / g_a;
    lim = 64'd1 << (WIDTH - 1);
    if (den > lim - 1 || mag > (neg ? lim : lim - 1)) begin
      r.status = ST_OVERFLOW;
      return r;
    end
    r.num = neg ? 32'(64'd0 - mag) : mag[31:0];
    r.den = den[30:0];
    return r;
  endfunction

  // profile: 0 small, 1 sixteen-bit, 2 full range, else boundary values
  function automatic logic [31:0] draw_operand(input int unsigned profile);
    logic [31:0] r;
    r = $urandom;
    case (profile)
      0: return 32'($urandom_range(0, 40)) - 32'd20;
      1: return {{16{r[15]}}, r[15:0]};
      2: return r;
      default: begin
        case ($urandom_range(0, 5))
          0: return 32'd0;
          1: return 32'd1;
          2: return 32'hffff_ffff;
          3: return 32'h8000_0000;
          4: return 32'h7fff_ffff;
          default: return 32'h8000_0001;
        endcase
      end
    endcase
  endfunction

  // tvalid stays high from one call to the next unless a gap is drawn
  task automatic send_fraction_op(input action_e op, input logic [31:0] an, ad, bn, bd);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {bd, bn, ad, an};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk_i);
    expected_ratios.insert(expected_ratios.size(), reduce_fraction_op(op, an, ad, bn, bd));
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_ratios.size() != 0);
  endtask

  task automatic check_ratio_transfer();
    ratio_t want;
    if (expected_ratios.size() == 0) begin
      $error("result transfer with no result pending");
      mismatches++;
      return;
    end
    want = expected_ratios.pop_front();
    if (m_axis_tdata[31:0] !== want.num) begin
      $error("result_num: expected %0d, actual %0d", $signed(want.num),
             $signed(m_axis_tdata[31:0]));
      mismatches++;
    end
    if (m_axis_tdata[62:32] !== want.den) begin
      $error("result_den: expected %0d, actual %0d", want.den, m_axis_tdata[62:32]);
      mismatches++;
    end
    if (m_axis_tuser !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
      mismatches++;
    end
  endtask

  // result side: random stall per transfer, or a long hold-off when requested
  initial begin
    int unsigned stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = rx_idle_en ? $urandom_range(0, 19) : 0;
      if (rx_hold_cycles > 0) begin
        stall          = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk_i);
      check_ratio_transfer();
    end
  end

  task automatic test_directed_cases();
    send_fraction_op(ACT_ADD, 1, 2, 1, 3);
    send_fraction_op(ACT_SUB, 1, 2, 1, 3);
    send_fraction_op(ACT_MUL, -2, 3, 3, -4);
    send_fraction_op(ACT_DIV, 1, 2, -1, 4);
    // zero results come out as 0/1 whatever the signs
    send_fraction_op(ACT_ADD, 1, 2, -1, 2);
    send_fraction_op(ACT_MUL, 0, -5, 7, -3);
    send_fraction_op(ACT_SUB, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_fraction_op(ACT_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    // zero denominators and division by a zero fraction
    send_fraction_op(ACT_ADD, 5, 0, 1, 1);
    send_fraction_op(ACT_SUB, 1, 1, 5, 0);
    send_fraction_op(ACT_MUL, 0, 0, 0, 0);
    send_fraction_op(ACT_DIV, 3, 4, 0, -7);
    send_fraction_op(ACT_DIV, 0, 4, 0, 7);
    // range edges and overflow
    send_fraction_op(ACT_MUL, 32'h8000_0000, 1, -1, 1);
    send_fraction_op(ACT_ADD, 32'h8000_0000, 1, 0, 1);
    send_fraction_op(ACT_DIV, 1, 32'h8000_0000, 1, 1);
    send_fraction_op(ACT_MUL, 1, 32'h8000_0000, 2, 1);
    send_fraction_op(ACT_MUL, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
    send_fraction_op(ACT_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 32'h7fff_ffff);
    send_fraction_op(ACT_MUL, 1, 65536, 1, 65536);
    send_fraction_op(ACT_ADD, 32'h7fff_ffff, 32'h8000_0000, 1, 32'h8000_0000);
    send_fraction_op(ACT_DIV, -6, -4, 9, -2);
    send_fraction_op(ACT_DIV, -1, -1, 1, 1);
    send_fraction_op(ACT_SUB, 32'h8000_0000, -1, 32'h7fff_ffff, 1);
  endtask

  task automatic test_random_ops(input int unsigned count);
    int unsigned  mix;
    logic [31:0]  f[4];
    for (int unsigned i = 0; i < count; i++) begin
      mix = $urandom_range(0, 9);
      for (int k = 0; k < 4; k++) begin
        if (mix <= 3)      f[k] = draw_operand(0);
        else if (mix <= 5) f[k] = draw_operand(1);
        else if (mix <= 7) f[k] = draw_operand(2);
        else               f[k] = draw_operand($urandom_range(0, 3));
      end
      send_fraction_op(action_e'($urandom_range(0, 3)), f[0], f[1], f[2], f[3]);
    end
  endtask

  // receiver holds off long enough for the unit to fill and stall its input
  task automatic test_output_backpressure();
    wait_for_results();
    tx_idle_en     = 1'b0;
    rx_hold_cycles = 1500;
    test_random_ops(10);
    tx_idle_en     = 1'b1;
  endtask

  task automatic test_drain_pauses();
    for (int unsigned n = 0; n < 4; n++) begin
      test_random_ops(5);
      wait_for_results();
    end
  endtask

  initial begin
    rst_ni         <= 1'b0;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= '0;
    s_axis_tuser   <= '0;
    mismatches     = 0;
    tx_idle_en     = 1'b1;
    rx_idle_en     = 1'b1;
    rx_hold_cycles = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_ops(150);
    tx_idle_en = 1'b0;
    test_random_ops(150);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b0;
    test_random_ops(150);
    tx_idle_en = 1'b0;
    test_random_ops(150);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_output_backpressure();
    test_drain_pauses();

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_ratios.size() != 0) begin
      $error("%0d results never arrived", expected_ratios.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
